// ===== design/lz_backref_unpacker_macros.svh =====
// Assertion macros used by the checker file.
`ifndef LZ_BACKREF_UNPACKER_MACROS_SVH
`define LZ_BACKREF_UNPACKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LZBU_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LZBU_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/lzbu_pkg.sv =====
`timescale 1ns / 1ps
package lzbu_pkg;

	localparam int CHUNK_BYTES = 32;
	localparam int LIMIT_W = 24;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd65536;

	localparam logic [7:0] OP_MEDIUM = 8'h80;
	localparam logic [7:0] OP_LONG = 8'hc0;
	localparam logic [7:0] OP_RUN = 8'he0;
	localparam logic [7:0] OP_FINAL = 8'hfc;

	typedef enum logic [2:0] {
		ST_RUN = 3'd0,
		ST_END = 3'd1,
		ST_FULL = 3'd2,
		ST_ERR = 3'd3,
		ST_TRUNC = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		PH_OPCODE = 3'd0,
		PH_HDR1 = 3'd1,
		PH_HDR2 = 3'd2,
		PH_HDR3 = 3'd3,
		PH_LIT = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_DISP,
		S_CRD,
		S_CWR,
		S_EMID,
		S_FIN,
		S_FEMIT
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic eval;
		logic rd;
		logic wr;
		logic fin;
		logic emit;
		logic emit_final;
		logic done;
	} lzbu_cmd_t;

	typedef struct packed {
		logic skip;
		logic copy_busy;
		logic copy_last;
		logic chunk_fill;
		logic out_free;
		logic have_out;
	} lzbu_stat_t;

endpackage

// ===== design/lzbu_ctrl.sv =====
`timescale 1ns / 1ps
module lzbu_ctrl import lzbu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input lzbu_stat_t st,
	output lzbu_cmd_t cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d = S_DISP;
			end
			S_DISP: begin
				if (st.skip) begin
					state_d = S_IDLE;
				end else if (st.copy_busy) begin
					state_d = S_CRD;
				end else begin
					state_d = S_FIN;
				end
			end
			S_CRD: begin
				cmd.rd = 1'b1;
				state_d = S_CWR;
			end
			S_CWR: begin
				cmd.wr = 1'b1;
				if (st.copy_last) begin
					state_d = S_FIN;
				end else if (st.chunk_fill) begin
					state_d = S_EMID;
				end else begin
					state_d = S_CRD;
				end
			end
			S_EMID: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d = S_CRD;
				end
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_FEMIT;
			end
			S_FEMIT: begin
				if (!st.have_out) begin
					cmd.done = 1'b1;
					state_d = S_IDLE;
				end else if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_final = 1'b1;
					cmd.done = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== design/lzbu_dp.sv =====
`timescale 1ns / 1ps
module lzbu_dp import lzbu_pkg::*; #(
	parameter int HISTORY_DEPTH = 131072
) (
	input logic clk,
	input logic arst_n,
	input lzbu_cmd_t cmd,
	output lzbu_stat_t st,
	input logic [7:0] in_byte,
	input logic in_last,
	input logic cfg_valid,
	input logic [LIMIT_W-1:0] cfg_data,
	output logic m_tvalid,
	input logic m_tready,
	output logic [263:0] m_tdata,
	output logic m_tlast,
	output logic [2:0] m_tuser
);

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int PW = AW + 1;

	logic [LIMIT_W-1:0] produced_q, limit_q;
	phase_t phase_q;
	logic [7:0] op_q, lits_q, lits_n;
	logic [17:0] dist_q;
	logic [10:0] clen_q, copy_left_q;
	logic stopped_q, skip_q, hd_pend_q, last_q;
	status_t term_q;
	logic [AW-1:0] wptr_q, wptr_n, raddr;
	logic [7:0] hist_q [HISTORY_DEPTH];
	logic [7:0] rd_q;
	logic [8*CHUNK_BYTES-1:0] chunk_q;
	logic [5:0] cnt_q;
	logic m_tvalid_q, m_tlast_q;
	logic [263:0] m_tdata_q;
	logic [2:0] m_tuser_q;

	logic is_match, full, over, bad_dist, put;
	logic [7:0] put_b;
	logic [LIMIT_W-1:0] room;
	logic [11:0] need;
	logic [PW-1:0] dext, wext, src_w;

	assign is_match = op_q < OP_RUN;
	assign full = produced_q >= limit_q;
	assign room = (limit_q > produced_q) ? limit_q - produced_q : '0;
	assign need = {4'b0, lits_q} + (is_match ? {1'b0, clen_q} : 12'd0);
	assign over = room < LIMIT_W'(need);
	assign bad_dist = is_match && (({1'b0, produced_q} + 25'(lits_q)) < 25'(dist_q));
	assign lits_n = (lits_q == 8'd0) ? 8'd0 : lits_q - 8'd1;

	always_comb begin
		dext = PW'(dist_q);
		if (dext == PW'(HISTORY_DEPTH)) begin
			dext = '0;
		end
		wext = PW'(wptr_q);
		src_w = (wext >= dext) ? wext - dext : wext + PW'(HISTORY_DEPTH) - dext;
	end
	assign raddr = src_w[AW-1:0];
	assign wptr_n = (wptr_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wptr_q + AW'(1);

	assign put = (cmd.accept && !stopped_q && phase_q == PH_LIT) || cmd.wr;
	assign put_b = cmd.wr ? rd_q : in_byte;

	always_ff @(posedge clk) begin
		if (put) begin
			hist_q[wptr_q] <= put_b;
		end
		if (cmd.rd) begin
			rd_q <= hist_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			produced_q <= '0;
			limit_q <= LIMIT_RESET;
			phase_q <= PH_OPCODE;
			op_q <= '0;
			lits_q <= '0;
			dist_q <= '0;
			clen_q <= '0;
			copy_left_q <= '0;
			stopped_q <= 1'b0;
			skip_q <= 1'b0;
			hd_pend_q <= 1'b0;
			last_q <= 1'b0;
			term_q <= ST_RUN;
			wptr_q <= '0;
			chunk_q <= '0;
			cnt_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (put) begin
				produced_q <= produced_q + LIMIT_W'(1);
				wptr_q <= wptr_n;
				chunk_q[cnt_q[4:0]*8 +: 8] <= put_b;
				cnt_q <= cnt_q + 6'd1;
			end
			if (cmd.accept) begin
				last_q <= in_last;
				term_q <= ST_RUN;
				hd_pend_q <= 1'b0;
				copy_left_q <= '0;
				skip_q <= stopped_q;
				if (stopped_q) begin
					if (in_last) begin
						produced_q <= '0;
						wptr_q <= '0;
						phase_q <= PH_OPCODE;
						op_q <= '0;
						lits_q <= '0;
						dist_q <= '0;
						clen_q <= '0;
						stopped_q <= 1'b0;
					end
				end else begin
					case (phase_q)
						PH_OPCODE: begin
							if (full) begin
								term_q <= ST_FULL;
							end else begin
								op_q <= in_byte;
								if (in_byte < OP_MEDIUM) begin
									lits_q <= {6'b0, in_byte[1:0]};
									clen_q <= 11'(in_byte[4:2]) + 11'd3;
									dist_q <= {8'b0, in_byte[6:5], 8'b0};
									phase_q <= PH_HDR1;
								end else if (in_byte < OP_LONG) begin
									lits_q <= '0;
									clen_q <= 11'(in_byte[5:0]) + 11'd4;
									dist_q <= '0;
									phase_q <= PH_HDR1;
								end else if (in_byte < OP_RUN) begin
									lits_q <= {6'b0, in_byte[1:0]};
									clen_q <= {1'b0, in_byte[3:2], 8'b0};
									dist_q <= {1'b0, in_byte[4], 16'b0};
									phase_q <= PH_HDR1;
								end else begin
									lits_q <= (in_byte >= OP_FINAL) ? {6'b0, in_byte[1:0]} :
										{1'b0, in_byte[4:0], 2'b0} + 8'd4;
									clen_q <= '0;
									dist_q <= '0;
									hd_pend_q <= 1'b1;
								end
							end
						end
						PH_HDR1: begin
							if (op_q < OP_MEDIUM) begin
								dist_q <= dist_q + 18'(in_byte) + 18'd1;
								hd_pend_q <= 1'b1;
							end else if (op_q < OP_LONG) begin
								lits_q <= {6'b0, in_byte[7:6]};
								dist_q <= {4'b0, in_byte[5:0], 8'b0};
								phase_q <= PH_HDR2;
							end else begin
								dist_q <= dist_q | {2'b0, in_byte, 8'b0};
								phase_q <= PH_HDR2;
							end
						end
						PH_HDR2: begin
							dist_q <= dist_q + 18'(in_byte) + 18'd1;
							if (op_q < OP_LONG) begin
								hd_pend_q <= 1'b1;
							end else begin
								phase_q <= PH_HDR3;
							end
						end
						PH_HDR3: begin
							clen_q <= clen_q + 11'(in_byte) + 11'd5;
							hd_pend_q <= 1'b1;
						end
						PH_LIT: begin
							lits_q <= lits_n;
							if (lits_n == 8'd0) begin
								phase_q <= PH_OPCODE;
								if (is_match) begin
									copy_left_q <= clen_q;
								end else if (op_q >= OP_FINAL) begin
									term_q <= ST_END;
								end
							end
						end
						default: begin
							phase_q <= PH_OPCODE;
						end
					endcase
				end
			end
			if (cmd.eval && hd_pend_q && !skip_q) begin
				hd_pend_q <= 1'b0;
				if (over || bad_dist) begin
					term_q <= ST_ERR;
				end else if (lits_q != 8'd0) begin
					phase_q <= PH_LIT;
				end else begin
					phase_q <= PH_OPCODE;
					if (is_match) begin
						copy_left_q <= clen_q;
					end else if (op_q >= OP_FINAL) begin
						term_q <= ST_END;
					end
				end
			end
			if (cmd.wr) begin
				copy_left_q <= copy_left_q - 11'd1;
			end
			if (cmd.fin && term_q == ST_RUN) begin
				if (phase_q == PH_OPCODE && full) begin
					term_q <= ST_FULL;
				end else if (last_q) begin
					term_q <= ST_TRUNC;
				end
			end
			if (cmd.emit) begin
				m_tvalid_q <= 1'b1;
				cnt_q <= '0;
				chunk_q <= '0;
			end
			if (cmd.done && term_q != ST_RUN) begin
				if (last_q) begin
					produced_q <= '0;
					wptr_q <= '0;
					phase_q <= PH_OPCODE;
					op_q <= '0;
					lits_q <= '0;
					dist_q <= '0;
					clen_q <= '0;
				end else begin
					stopped_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_tdata_q <= {2'b0, cnt_q, chunk_q};
			m_tlast_q <= cmd.emit_final && (term_q != ST_RUN);
			m_tuser_q <= cmd.emit_final ? term_q : ST_RUN;
		end
	end

	assign st.skip = skip_q;
	assign st.copy_busy = copy_left_q != 11'd0;
	assign st.copy_last = copy_left_q == 11'd1;
	assign st.chunk_fill = cnt_q == 6'(CHUNK_BYTES - 1);
	assign st.out_free = !m_tvalid_q || m_tready;
	assign st.have_out = (cnt_q != 6'd0) || (term_q != ST_RUN);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tlast = m_tlast_q;
	assign m_tuser = m_tuser_q;

endmodule

// ===== design/lz_backref_unpacker.sv =====
`timescale 1ns / 1ps
// Decodes an LZ77-style frame one compressed byte per input word and emits the
// decompressed bytes in words of up to 32 bytes, least significant byte first.
// After a header or literal byte is accepted, the controller steps through its
// evaluate, dispatch, finish and emit steps before the next byte can be taken;
// a byte dropped after the frame has ended passes only evaluate and dispatch.
// Each back-copied byte is a registered read of the history memory followed by
// its write-back; each full 32-byte word is handed out before the copy goes on.
// The block also waits whenever the output register is still held by the sink.
// The last word of a frame carries tlast and a nonzero status in tuser.
module lz_backref_unpacker import lzbu_pkg::*; #(
	parameter int HISTORY_DEPTH = 131072
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata,      // [7:0] in_byte
	input logic s_tlast,
	output logic m_tvalid,
	input logic m_tready,
	output logic [263:0] m_tdata,   // [63:0] lane0, [127:64] lane1, [191:128] lane2,
	                                // [255:192] lane3, [261:256] byte_count, rest zero
	output logic m_tlast,
	output logic [2:0] m_tuser,     // [2:0] status
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [LIMIT_W-1:0] cfg_data
);

	lzbu_cmd_t cmd;
	lzbu_stat_t st;

	assign cfg_ready = 1'b1;

	lzbu_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.st(st),
		.cmd(cmd)
	);

	lzbu_dp #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.st(st),
		.in_byte(s_tdata),
		.in_last(s_tlast),
		.cfg_valid(cfg_valid),
		.cfg_data(cfg_data),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

endmodule

// ===== design/lzbu_checker.sv =====
`timescale 1ns / 1ps
`include "lz_backref_unpacker_macros.svh"
module lzbu_checker (
	input logic clk,
	input logic arst_n,
	input logic m_tvalid,
	input logic m_tready,
	input logic [263:0] m_tdata,
	input logic m_tlast,
	input logic [2:0] m_tuser
);

	`LZBU_ASSERT_NXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")
	`LZBU_ASSERT_IMP(a_last_status, clk, arst_n, m_tvalid, m_tlast == (m_tuser != 3'd0), "status and last disagree")
	`LZBU_ASSERT_IMP(a_count, clk, arst_n, m_tvalid, m_tdata[261:256] <= 6'd32, "byte count above chunk size")
	`LZBU_ASSERT_IMP(a_status, clk, arst_n, m_tvalid, m_tuser <= 3'd4, "status code out of range")

endmodule

bind lz_backref_unpacker lzbu_checker u_chk (.*);
